// ===== hdl/pplb_pkg.sv =====
// Package for the ping-pong line buffer: payload structs, register indexes,
// reset values and default sizes. Used by every module in hdl/.
package pplb_pkg;

   localparam int MAX_COLUMNS_DEF = 4096;
   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int MAX_SAMPLES_DEF = 4;

   localparam int NUM_LANES  = 4;
   localparam int LANE_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int COL_W      = 12;
   localparam int LEN_W      = 13;
   localparam int AFE_W      = 8;
   localparam int CNT_W      = 3;
   localparam int FILL_OUT_W = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [LEN_W-1:0] LINE_LENGTH_RST = 13'd2048;
   localparam logic [AFE_W-1:0] AFE_COUNT_RST   = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AFE_COUNT   = 1'd1;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic             write_enable;
      logic [COL_W-1:0] write_column;
      logic             write_bank;
      logic [CNT_W-1:0] sample_count;
      sample_type       sample_a;
      sample_type       sample_b;
      sample_type       sample_c;
      sample_type       sample_d;
      logic             read_enable;
      logic [COL_W-1:0] read_column;
      logic             read_bank;
   } req_payload_type;

   typedef struct packed {
      sample_type            read_data;
      logic                  line_done;
      logic [FILL_OUT_W-1:0] fifo_fill;
      logic                  fifo_drop;
      logic [LEN_W-1:0]      line_fill;
      logic [AFE_W-1:0]      stream_count;
   } rsp_payload_type;

endpackage

// ===== hdl/pplb_lane_ram.sv =====
// One column lane of the bank store: simple dual-port RAM, registered read.
// Depends on pplb_pkg for the sample type.
module pplb_lane_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  pplb_pkg::sample_type wdata,
   input  logic                re,
   input  logic [AW-1:0]       raddr,
   output pplb_pkg::sample_type rdata
);

   pplb_pkg::sample_type mem [DEPTH];
   pplb_pkg::sample_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/pplb_fifo.sv =====
// Compacting sample queue: pushes up to four samples behind the stored ones
// and drops the drained entries from the head in the same beat. Uses pplb_pkg.
module pplb_fifo #(
   parameter int DEPTH = pplb_pkg::FIFO_DEPTH_DEF,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      update,
   input  logic                      push_en,
   input  logic [pplb_pkg::CNT_W-1:0] push_cnt,
   input  pplb_pkg::sample_type      samples [pplb_pkg::NUM_LANES],
   input  logic [pplb_pkg::CNT_W-1:0] drain_cnt,
   output logic [CW-1:0]             avail,
   output logic                      overflow,
   output pplb_pkg::sample_type      head [pplb_pkg::NUM_LANES]
);

   localparam int VLEN = DEPTH + pplb_pkg::NUM_LANES;
   localparam int VW   = $clog2(VLEN + 1);

   pplb_pkg::sample_type entry_ff [DEPTH];
   pplb_pkg::sample_type entry_in [DEPTH];
   pplb_pkg::sample_type seq      [VLEN];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [CW-1:0]        free_slots;
   logic [CW-1:0]        pushes;
   logic [VW-1:0]        diff [VLEN];

   // stored entries followed by the incoming samples
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         diff[j] = VW'(j) - VW'(count_ff);
         seq[j]  = (VW'(j) < VW'(count_ff)) ? entry_ff[j]
                                            : samples[diff[j][pplb_pkg::LANE_W-1:0]];
      end
      for (int j = DEPTH; j < VLEN; j++) begin
         diff[j] = VW'(j) - VW'(count_ff);
         seq[j]  = samples[diff[j][pplb_pkg::LANE_W-1:0]];
      end
   end

   always_comb begin
      free_slots = CW'(DEPTH) - count_ff;
      overflow   = push_en && (CW'(push_cnt) > free_slots);
      if (!push_en) begin
         pushes = '0;
      end else if (CW'(push_cnt) > free_slots) begin
         pushes = free_slots;
      end else begin
         pushes = CW'(push_cnt);
      end
      avail    = count_ff + pushes;
      count_in = avail - CW'(drain_cnt);
      for (int j = 0; j < pplb_pkg::NUM_LANES; j++) begin
         head[j] = seq[j];
      end
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = seq[i];
         for (int kk = 1; kk <= pplb_pkg::NUM_LANES; kk++) begin
            if (drain_cnt == pplb_pkg::CNT_W'(kk)) begin
               entry_in[i] = seq[i + kk];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (update) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== hdl/pingpong_line_buffer_with_fifo.sv =====
// Top level of the ping-pong line buffer: sample queue, four-lane bank RAM,
// result pipeline and registers. Depends on pplb_pkg, pplb_fifo, pplb_lane_ram.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_payload_type
//   rsp       out        rsp_valid/rsp_stall   rsp_payload_type
//   csr       in         csr_we                csr_index, csr_wdata
//
// One beat per cycle unless req_stall is high; a result is registered twice.
// Columns are interleaved over four RAM lanes, so the up to four writes of a
// beat land in different lanes; a read of a column written in the same beat is
// forwarded. After reset a clearing pass zeroes every lane RAM word,
// 2*ceil(MAX_COLUMNS/4) per lane (2048 by default), while req_stall is held.
// rsp_stall backs up through one staging register and the output register.
module pingpong_line_buffer_with_fifo #(
   parameter int MAX_COLUMNS = pplb_pkg::MAX_COLUMNS_DEF,
   parameter int FIFO_DEPTH  = pplb_pkg::FIFO_DEPTH_DEF,
   parameter int MAX_SAMPLES = pplb_pkg::MAX_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pplb_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pplb_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_we,
   input  logic [pplb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pplb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NL         = pplb_pkg::NUM_LANES;
   localparam int LW         = pplb_pkg::LANE_W;
   localparam int LANE_DEPTH = (MAX_COLUMNS + NL - 1) / NL;
   localparam int RAM_DEPTH  = 2 * LANE_DEPTH;
   localparam int AW         = $clog2(RAM_DEPTH);
   localparam int CLW        = $clog2(MAX_COLUMNS + 1);
   localparam int CMP_W      = (CLW > pplb_pkg::LEN_W) ? CLW : pplb_pkg::LEN_W;
   localparam int SAMP_MAX   = (MAX_SAMPLES < NL) ? MAX_SAMPLES : NL;
   localparam int CW         = $clog2(FIFO_DEPTH + 1);
   localparam int CNT_W      = pplb_pkg::CNT_W;
   localparam int LEN_W      = pplb_pkg::LEN_W;

   typedef struct packed {
      logic                            rd_valid;
      logic [LW-1:0]                   rd_lane;
      logic                            fwd;
      pplb_pkg::sample_type            fwd_data;
      logic                            line_done;
      logic [pplb_pkg::FILL_OUT_W-1:0] fifo_fill;
      logic                            fifo_drop;
      logic [LEN_W-1:0]                line_fill;
      logic [pplb_pkg::AFE_W-1:0]      stream_count;
   } s1_type;

   logic                       accept;
   logic                       s1_move;
   logic                       clear_ff;
   logic                       clear_in;
   logic [AW-1:0]              clear_addr_ff;
   logic [AW-1:0]              clear_addr_in;
   logic [LEN_W-1:0]           line_length_ff;
   logic [LEN_W-1:0]           line_length_in;
   logic [pplb_pkg::AFE_W-1:0] afe_count_ff;
   logic [pplb_pkg::AFE_W-1:0] afe_count_in;
   logic [LEN_W-1:0]           fill_ff;
   logic [LEN_W-1:0]           fill_in;
   logic [LEN_W:0]             fill_sum;
   pplb_pkg::sample_type       held_ff;
   pplb_pkg::sample_type       held_in;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   s1_type                     s1_ff;
   s1_type                     s1_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   pplb_pkg::rsp_payload_type  rsp_ff;
   pplb_pkg::rsp_payload_type  rsp_in;

   logic [CNT_W-1:0]           cnt;
   logic [CNT_W-1:0]           drain_k;
   logic [CW-1:0]              fifo_avail;
   logic                       fifo_ovf;
   pplb_pkg::sample_type       samples [NL];
   pplb_pkg::sample_type       head    [NL];
   logic [CMP_W-1:0]           col_w;
   logic [CMP_W-1:0]           limit;
   logic [CMP_W-1:0]           room;
   logic                       done;

   logic [LW-1:0]              j_off     [NL];
   logic [CMP_W-1:0]           wcol      [NL];
   logic [CMP_W-1:0]           wrow      [NL];
   logic                       item_we   [NL];
   logic [AW-1:0]              item_addr [NL];
   logic                       lane_we   [NL];
   logic [AW-1:0]              lane_waddr[NL];
   pplb_pkg::sample_type       lane_wdata[NL];
   pplb_pkg::sample_type       lane_rdata[NL];
   logic [CMP_W-1:0]           rrow;
   logic [AW-1:0]              raddr;
   logic [LW-1:0]              rlane;
   logic                       rd_valid;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign samples[0] = req_data.sample_a;
   assign samples[1] = req_data.sample_b;
   assign samples[2] = req_data.sample_c;
   assign samples[3] = req_data.sample_d;

   pplb_fifo #(
      .DEPTH (FIFO_DEPTH),
      .CW    (CW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .update    (accept),
      .push_en   (req_data.write_enable),
      .push_cnt  (cnt),
      .samples   (samples),
      .drain_cnt (drain_k),
      .avail     (fifo_avail),
      .overflow  (fifo_ovf),
      .head      (head)
   );

   // drain count, line end and fill level
   always_comb begin
      cnt = (req_data.sample_count == '0) ? CNT_W'(1) : req_data.sample_count;
      if (cnt > CNT_W'(SAMP_MAX)) begin
         cnt = CNT_W'(SAMP_MAX);
      end
      col_w = CMP_W'(req_data.write_column);
      limit = (CMP_W'(line_length_ff) < CMP_W'(MAX_COLUMNS)) ? CMP_W'(line_length_ff)
                                                             : CMP_W'(MAX_COLUMNS);
      room  = (limit > col_w) ? (limit - col_w) : '0;
      drain_k = cnt;
      if (fifo_avail < CW'(drain_k)) begin
         drain_k = CNT_W'(fifo_avail);
      end
      if (room < CMP_W'(drain_k)) begin
         drain_k = CNT_W'(room);
      end
      done = (drain_k != '0) && ((col_w + CMP_W'(drain_k)) == CMP_W'(line_length_ff));
      fill_sum = {1'b0, fill_ff} + (LEN_W + 1)'(drain_k);
      if (done) begin
         fill_in = '0;
      end else if (fill_ff >= line_length_ff) begin
         fill_in = fill_ff;
      end else if (fill_sum > {1'b0, line_length_ff}) begin
         fill_in = line_length_ff;
      end else begin
         fill_in = fill_sum[LEN_W-1:0];
      end
   end

   // lane write ports and read address
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         j_off[l]     = LW'(l) - req_data.write_column[LW-1:0];
         wcol[l]      = col_w + CMP_W'(j_off[l]);
         wrow[l]      = wcol[l] >> LW;
         item_addr[l] = req_data.write_bank ? (AW'(LANE_DEPTH) + AW'(wrow[l]))
                                            : AW'(wrow[l]);
         item_we[l]   = accept && (CNT_W'(j_off[l]) < drain_k);
         lane_we[l]   = clear_ff || item_we[l];
         lane_waddr[l] = clear_ff ? clear_addr_ff : item_addr[l];
         lane_wdata[l] = clear_ff ? '0 : head[j_off[l]];
      end
      rrow     = CMP_W'(req_data.read_column) >> LW;
      raddr    = req_data.read_bank ? (AW'(LANE_DEPTH) + AW'(rrow)) : AW'(rrow);
      rlane    = req_data.read_column[LW-1:0];
      rd_valid = req_data.read_enable && (CMP_W'(req_data.read_column) < limit);
   end

   for (genvar g = 0; g < NL; g++) begin : g_lane
      pplb_lane_ram #(
         .DEPTH (RAM_DEPTH),
         .AW    (AW)
      ) u_ram (
         .clock (clock),
         .we    (lane_we[g]),
         .waddr (lane_waddr[g]),
         .wdata (lane_wdata[g]),
         .re    (accept && rd_valid && (rlane == LW'(g))),
         .raddr (raddr),
         .rdata (lane_rdata[g])
      );
   end

   always_comb begin
      s1_in.rd_valid       = rd_valid;
      s1_in.rd_lane        = rlane;
      s1_in.fwd            = rd_valid && item_we[rlane] && (item_addr[rlane] == raddr);
      s1_in.fwd_data       = head[j_off[rlane]];
      s1_in.line_done      = done;
      s1_in.fifo_fill      = pplb_pkg::FILL_OUT_W'(fifo_avail - CW'(drain_k));
      s1_in.fifo_drop      = fifo_ovf;
      s1_in.line_fill      = fill_in;
      s1_in.stream_count   = (afe_count_ff == '0) ? pplb_pkg::AFE_W'(1) : afe_count_ff;
      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_valid_ff && rsp_stall);
      if (!s1_ff.rd_valid) begin
         held_in = held_ff;
      end else if (s1_ff.fwd) begin
         held_in = s1_ff.fwd_data;
      end else begin
         held_in = lane_rdata[s1_ff.rd_lane];
      end
      rsp_in.read_data      = held_in;
      rsp_in.line_done      = s1_ff.line_done;
      rsp_in.fifo_fill      = s1_ff.fifo_fill;
      rsp_in.fifo_drop      = s1_ff.fifo_drop;
      rsp_in.line_fill      = s1_ff.line_fill;
      rsp_in.stream_count   = s1_ff.stream_count;
   end

   always_comb begin
      line_length_in = line_length_ff;
      afe_count_in   = afe_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            pplb_pkg::CSR_LINE_LENGTH: begin
               line_length_in = csr_wdata[LEN_W-1:0];
            end
            pplb_pkg::CSR_AFE_COUNT: begin
               afe_count_in = csr_wdata[pplb_pkg::AFE_W-1:0];
            end
         endcase
      end
      clear_in      = clear_ff && (clear_addr_ff != AW'(RAM_DEPTH - 1));
      clear_addr_in = clear_ff ? (clear_addr_ff + AW'(1)) : clear_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
         line_length_ff <= pplb_pkg::LINE_LENGTH_RST;
         afe_count_ff   <= pplb_pkg::AFE_COUNT_RST;
         fill_ff        <= '0;
         held_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clear_ff       <= clear_in;
         clear_addr_ff  <= clear_addr_in;
         line_length_ff <= line_length_in;
         afe_count_ff   <= afe_count_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
         if (s1_move) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   a_no_beat_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !accept)
      else $error("request beat taken during bank clear");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_avail <= CW'(FIFO_DEPTH))
      else $error("sample queue level above depth");

   a_done_clears_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.line_done) |-> (rsp_ff.line_fill == '0))
      else $error("line end without fill clear");

   a_fwd_needs_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.fwd) |-> s1_ff.rd_valid)
      else $error("forward flagged on a beat without a valid read");

endmodule

// ===== bench/testbench.sv =====
// Testbench for pingpong_line_buffer_with_fifo: a directed table, then random
// phases with paced beats on both channels; results checked vs. table or predictor.
// Depends on pplb_pkg and the RTL in hdl/.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pplb_pkg::*;

   localparam int unsigned COLS    = MAX_COLUMNS_DEF;
   localparam int unsigned QDEPTH  = FIFO_DEPTH_DEF;
   localparam int unsigned LANES   = MAX_SAMPLES_DEF;
   localparam int unsigned PHASES  = 8;
   localparam int unsigned PER_PHASE = 125;

   typedef enum logic [1:0] {ROW_MODEL, ROW_TYPED, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      req_payload_type       beat;
      rsp_payload_type       want;
   } vector_row_type;

   // beat: wen, wcol, wbank, count, a, b, c, d, ren, rcol, rbank
   // want: read_data, line_done, fifo_fill, overflow, line_fill, streams
   localparam vector_row_type DIR_TABLE [0:22] = '{
      '{ROW_TYPED, '0, '0, '{0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0},
        '{16'h0000, 0, 0, 0, 0, 1}},
      '{ROW_TYPED, '0, '0, '{1, 0, 0, 4, 16'hFFFF, 16'h0000, 16'h1234, 16'hABCD, 1, 3, 0},
        '{16'hABCD, 0, 0, 0, 4, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 1, 0, 16'h8001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 4095, 1},
        '{16'hABCD, 0, 1, 0, 4, 1}},
      '{ROW_TYPED, '0, '0, '{0, 2044, 1, 7, 0, 0, 0, 0, 1, 2044, 1},
        '{16'h8001, 0, 0, 0, 5, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 0, 4, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0, 0, 0},
        '{16'h8001, 0, 4, 0, 5, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 0, 4, 16'h5555, 16'h6666, 16'h7777, 16'h8888, 0, 0, 0},
        '{16'h8001, 0, 8, 0, 5, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 0, 4, 16'h9999, 16'hAAAA, 16'hBBBB, 16'hCCCC, 0, 0, 0},
        '{16'h8001, 0, 12, 0, 5, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 0, 4, 16'hDDDD, 16'hEEEE, 16'hF0F0, 16'h0F0F, 0, 0, 0},
        '{16'h8001, 0, 16, 0, 5, 1}},
      '{ROW_TYPED, '0, '0, '{1, 4095, 0, 4, 16'hC3C3, 16'h3C3C, 16'hA5A5, 16'h5A5A, 0, 0, 0},
        '{16'h8001, 0, 16, 1, 5, 1}},
      '{ROW_TYPED, '0, '0, '{0, 2044, 0, 4, 0, 0, 0, 0, 0, 0, 0},
        '{16'h8001, 1, 12, 0, 0, 1}},
      '{ROW_REG, CSR_LINE_LENGTH, 13'd0, '0, '0},
      '{ROW_TYPED, '0, '0, '{0, 0, 0, 4, 0, 0, 0, 0, 1, 0, 0},
        '{16'h8001, 0, 12, 0, 0, 1}},
      '{ROW_REG, CSR_AFE_COUNT, 13'd0, '0, '0},
      '{ROW_REG, CSR_LINE_LENGTH, 13'd8191, '0, '0},
      '{ROW_MODEL, '0, '0, '{0, 4092, 1, 4, 0, 0, 0, 0, 1, 4095, 1}, '0},
      '{ROW_REG, CSR_AFE_COUNT, 13'd255, '0, '0},
      '{ROW_REG, CSR_LINE_LENGTH, 13'd4096, '0, '0},
      '{ROW_MODEL, '0, '0, '{1, 4095, 0, 1, 16'hFFFF, 0, 0, 0, 1, 4095, 0}, '0},
      '{ROW_REG, CSR_LINE_LENGTH, 13'd3, '0, '0},
      '{ROW_MODEL, '0, '0, '{0, 0, 1, 2, 0, 0, 0, 0, 1, 2, 1}, '0},
      '{ROW_MODEL, '0, '0, '{0, 0, 1, 4, 0, 0, 0, 0, 1, 0, 1}, '0},
      '{ROW_REG, CSR_LINE_LENGTH, 13'd1, '0, '0},
      '{ROW_MODEL, '0, '0, '{1, 0, 0, 1, 16'h5A5A, 0, 0, 0, 1, 0, 0}, '0}
   };

   localparam int unsigned LEN_PLAN [0:PHASES-1] = '{16, 4096, 0, 5, 8191, 1, 37, 4097};
   localparam int unsigned AFE_PLAN [0:PHASES-1] = '{255, 0, 1, 128, 7, 255, 0, 3};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   sample_type  bank_image [0:2*COLS-1];
   sample_type  sample_queue [0:QDEPTH-1];
   int unsigned queue_head;
   int unsigned queue_level;
   int unsigned line_count;
   sample_type  held_word;
   int unsigned line_len;
   int unsigned afe_reg;
   int unsigned next_col;

   rsp_payload_type awaited_status [$];
   int unsigned err_count = 0;
   bit no_idle = 1'b0;

   pingpong_line_buffer_with_fifo u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int unsigned pause_len();
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic rsp_payload_type line_buffer_step(req_payload_type r);
      rsp_payload_type o;
      sample_type lane_in [0:3];
      int unsigned n, lim, col, moved;
      o = '0;
      lane_in[0] = r.sample_a;
      lane_in[1] = r.sample_b;
      lane_in[2] = r.sample_c;
      lane_in[3] = r.sample_d;
      n = r.sample_count;
      if (n == 0) n = 1;
      if (n > LANES) n = LANES;
      if (r.write_enable) begin
         for (int i = 0; i < n; i++) begin
            if (queue_level < QDEPTH) begin
               sample_queue[(queue_head + queue_level) % QDEPTH] = lane_in[i];
               queue_level++;
            end else begin
               o.fifo_drop = 1'b1;
               break;
            end
         end
      end
      lim = (line_len < COLS) ? line_len : COLS;
      col = r.write_column;
      moved = 0;
      while (queue_level > 0 && col < lim && moved < n) begin
         bank_image[r.write_bank * COLS + col] = sample_queue[queue_head];
         queue_head = (queue_head + 1) % QDEPTH;
         queue_level--;
         col++;
         moved++;
         if (line_count < line_len) line_count++;
         if (col >= line_len) begin
            o.line_done = 1'b1;
            line_count = 0;
            break;
         end
      end
      next_col = o.line_done ? 0 : col;
      if (r.read_enable && r.read_column < lim)
         held_word = bank_image[r.read_bank * COLS + r.read_column];
      o.read_data      = held_word;
      o.fifo_fill      = FILL_OUT_W'(queue_level);
      o.line_fill      = LEN_W'(line_count);
      o.stream_count   = (afe_reg == 0) ? AFE_W'(1) : AFE_W'(afe_reg);
      return o;
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type b;
      int unsigned lim;
      lim = (line_len < COLS) ? line_len : COLS;
      b.write_enable = ($urandom_range(0, 9) < 8);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: b.write_column = COL_W'(next_col);
         6, 7: b.write_column = COL_W'($urandom);
         default: b.write_column = (lim > 8) ? COL_W'($urandom_range(lim - 8, COLS - 1))
                                             : COL_W'($urandom_range(0, 15));
      endcase
      b.write_bank   = 1'($urandom_range(0, 1));
      b.sample_count = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(1, 4))
                                                  : CNT_W'($urandom_range(0, 7));
      b.sample_a     = sample_type'($urandom);
      b.sample_b     = sample_type'($urandom);
      b.sample_c     = sample_type'($urandom);
      b.sample_d     = sample_type'($urandom);
      b.read_enable  = ($urandom_range(0, 3) != 0);
      b.read_column  = (lim > 0 && $urandom_range(0, 3) != 0) ? COL_W'($urandom_range(0, lim - 1))
                                                              : COL_W'($urandom);
      b.read_bank    = 1'($urandom_range(0, 1));
      return b;
   endfunction

   task automatic send_beat(req_payload_type beat, bit pinned, rsp_payload_type pinned_want);
      int unsigned gap;
      rsp_payload_type predicted;
      gap = pause_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predicted = line_buffer_step(beat);
      awaited_status.insert(awaited_status.size(), pinned ? pinned_want : predicted);
   endtask

   // drop valid, then wait for every outstanding result to be checked
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LINE_LENGTH) line_len = val;
      else afe_reg = val[AFE_W-1:0];
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_status.size() == 0) begin
            $error("result beat with none outstanding: %h", rsp_data);
            err_count++;
         end else begin
            want = awaited_status.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("line_done", want.line_done, rsp_data.line_done);
            check_field("fifo_fill", want.fifo_fill, rsp_data.fifo_fill);
            check_field("fifo_drop", want.fifo_drop, rsp_data.fifo_drop);
            check_field("line_fill", want.line_fill, rsp_data.line_fill);
            check_field("stream_count", want.stream_count, rsp_data.stream_count);
         end
      end
   end

   initial begin : rsp_pacing
      int unsigned hold;
      forever begin
         hold = pause_len();
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      foreach (bank_image[i]) bank_image[i] = '0;
      foreach (sample_queue[i]) sample_queue[i] = '0;
      queue_head  = 0;
      queue_level = 0;
      line_count  = 0;
      held_word   = '0;
      line_len    = LINE_LENGTH_RST;
      afe_reg     = AFE_COUNT_RST;
      next_col    = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i]) begin
         if (DIR_TABLE[i].kind == ROW_REG) begin
            settle();
            write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].reg_val);
         end else begin
            send_beat(DIR_TABLE[i].beat, DIR_TABLE[i].kind == ROW_TYPED, DIR_TABLE[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_reg(CSR_LINE_LENGTH, (phase == 6) ? CSR_DATA_W'($urandom_range(2, 300))
                                                 : CSR_DATA_W'(LEN_PLAN[phase]));
         write_reg(CSR_AFE_COUNT, CSR_DATA_W'(AFE_PLAN[phase]));
         no_idle = (phase % 3 == 1);
         repeat (PER_PHASE) send_beat(random_beat(), 1'b0, '0);
      end

      settle();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
